// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FSEA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define FSEA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/core/fsea_pkg.sv
// ----------------------------------------------------------------------------
// fsea_pkg
// Widths, codes and shared types of the fixed-size entry allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package fsea_pkg;

	localparam int FSEA_BUFFER_BYTES_LOG2 = 18;
	localparam int FSEA_CHUNK_BYTES       = 8192;
	localparam int FSEA_UNIT_BYTES        = 64;

	localparam int ADDR_W     = 18;
	localparam int BASE_W     = 5;
	localparam int SIZE_W     = 9;
	localparam int COUNT_W    = 13;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_EXHAUSTED = 2'd1;
	localparam status_t ST_OUTSIDE   = 2'd2;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_BASE_CHUNK = 2'd0;
	localparam cfg_idx_t REG_SIZE_CODE  = 2'd1;
	localparam cfg_idx_t REG_COUNT      = 2'd2;

	typedef struct packed {
		logic clear;
		logic busy;
	} cfg_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/fsea_channels.sv
// ----------------------------------------------------------------------------
// fsea channels
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface fsea_req_if import fsea_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [ADDR_W-1:0] entry_address;
	modport source (output valid, kind, entry_address, input ready);
	modport sink (input valid, kind, entry_address, output ready);
endinterface

interface fsea_rsp_if import fsea_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   granted_address;
	logic [STATUS_W-1:0] status;
	modport source (output valid, granted_address, status, input ready);
	modport sink (input valid, granted_address, status, output ready);
endinterface

interface fsea_cfg_if import fsea_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/fsea_link_ram.sv
// ----------------------------------------------------------------------------
// fsea_link_ram
// Link table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module fsea_link_ram import fsea_pkg::*; #(
	parameter int ADDR_BITS = 12,
	parameter int DATA_BITS = 13
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [ADDR_BITS-1:0] wr_addr,
	input  wire logic [DATA_BITS-1:0] wr_data,
	input  wire logic                 rd_en,
	input  wire logic [ADDR_BITS-1:0] rd_addr,
	output logic      [DATA_BITS-1:0] rd_data
);

	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/fsea_region_cfg.sv
// ----------------------------------------------------------------------------
// fsea_region_cfg
// Region registers and the two-stage region end computation.
// ----------------------------------------------------------------------------
`default_nettype none
module fsea_region_cfg import fsea_pkg::*; #(
	parameter int BUFFER_BYTES_LOG2 = FSEA_BUFFER_BYTES_LOG2,
	parameter int CHUNK_BYTES       = FSEA_CHUNK_BYTES,
	parameter int UNIT_BYTES        = FSEA_UNIT_BYTES,
	localparam int UNIT_LOG2  = $clog2(UNIT_BYTES),
	localparam int CHUNK_LOG2 = $clog2(CHUNK_BYTES),
	localparam int UNIT_W     = BUFFER_BYTES_LOG2 - UNIT_LOG2,
	localparam int END_W      = UNIT_W + 1,
	localparam int START_W    = BASE_W + CHUNK_LOG2 - UNIT_LOG2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	fsea_cfg_if.sink                cfg,
	output cfg_ctl_t                ctl,
	output logic      [START_W-1:0] start_unit,
	output logic      [END_W-1:0]   region_end,
	output logic      [SIZE_W-1:0]  size_code,
	output logic      [COUNT_W-1:0] entry_count
);

	localparam int SPAN_W = COUNT_W + SIZE_W + 1;
	localparam int SUM_W  = ((START_W > SPAN_W) ? START_W : SPAN_W) + 1;
	localparam int CMP_W  = (SUM_W > END_W) ? SUM_W : END_W;

	logic [BASE_W-1:0]  base_q;
	logic [SIZE_W-1:0]  size_q;
	logic [COUNT_W-1:0] count_q;
	logic [END_W-1:0]   region_end_q;
	logic [SPAN_W-1:0]  span_s2;
	logic               pend_s1;
	logic               pend_s2;
	logic               wr_hit;
	logic [BASE_W+CHUNK_LOG2-1:0] base_bytes;
	logic [CMP_W-1:0]   end_sum;
	logic [CMP_W-1:0]   buf_units;

	assign cfg.ready = 1'b1;

	always_comb begin
		unique case (cfg.index)
			REG_BASE_CHUNK, REG_SIZE_CODE, REG_COUNT: wr_hit = cfg.valid;
			default: wr_hit = 1'b0;
		endcase
	end

	assign base_bytes = {base_q, {CHUNK_LOG2{1'b0}}};
	assign start_unit = START_W'(base_bytes >> UNIT_LOG2);
	assign end_sum    = CMP_W'(start_unit) + CMP_W'(span_s2);
	assign buf_units  = CMP_W'(1) << UNIT_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			size_q       <= '0;
			count_q      <= '0;
			region_end_q <= '0;
			span_s2      <= '0;
			pend_s1      <= 1'b0;
			pend_s2      <= 1'b0;
		end else begin
			pend_s1 <= wr_hit;
			pend_s2 <= pend_s1;
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_BASE_CHUNK: base_q  <= cfg.data[BASE_W-1:0];
					REG_SIZE_CODE:  size_q  <= cfg.data[SIZE_W-1:0];
					REG_COUNT:      count_q <= cfg.data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (pend_s1) begin
				span_s2 <= SPAN_W'(count_q) * (SPAN_W'(size_q) + SPAN_W'(1));
			end
			if (pend_s2) begin
				region_end_q <= (end_sum > buf_units) ? END_W'(buf_units) : END_W'(end_sum);
			end
		end
	end

	assign ctl.clear   = wr_hit;
	assign ctl.busy    = pend_s1 | pend_s2;
	assign region_end  = region_end_q;
	assign size_code   = size_q;
	assign entry_count = count_q;

endmodule
`default_nettype wire

// File: rtl/core/fixed_size_entry_allocator.sv
// Free and bump allocations: result registered in the cycle after acceptance,
// one item per cycle unless the response stalls. Free-list pops wait in ST_POP
// for the link table read. A register write holds the request channel while the
// region end is recomputed. Asynchronous reset clears the registers and
// the free list; the link table is not cleared.
// ----------------------------------------------------------------------------
// fixed_size_entry_allocator
// Fixed-size entry pool with a LIFO free list and a bump pointer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module fixed_size_entry_allocator import fsea_pkg::*; #(
	parameter int BUFFER_BYTES_LOG2 = FSEA_BUFFER_BYTES_LOG2,
	parameter int CHUNK_BYTES       = FSEA_CHUNK_BYTES,
	parameter int UNIT_BYTES        = FSEA_UNIT_BYTES
) (
	input  wire logic clk,
	input  wire logic arst_n,
	fsea_cfg_if.sink  cfg,
	fsea_req_if.sink  req,
	fsea_rsp_if.source rsp
);

	localparam int UNIT_LOG2  = $clog2(UNIT_BYTES);
	localparam int CHUNK_LOG2 = $clog2(CHUNK_BYTES);
	localparam int UNIT_W     = BUFFER_BYTES_LOG2 - UNIT_LOG2;
	localparam int END_W      = UNIT_W + 1;
	localparam int LINK_W     = UNIT_W + 1;
	localparam int START_W    = BASE_W + CHUNK_LOG2 - UNIT_LOG2;
	localparam int SPAN_W     = COUNT_W + SIZE_W + 1;
	localparam int SUM_W      = ((START_W > SPAN_W) ? START_W : SPAN_W) + 1;
	localparam int CMP_W      = (SUM_W > END_W) ? SUM_W : END_W;
	localparam int FUNIT_W    = ADDR_W - UNIT_LOG2;

	typedef enum logic {ST_IDLE, ST_POP} state_t;

	state_t              state_q;
	cfg_ctl_t            cfg_ctl;
	logic [START_W-1:0]  start_unit;
	logic [END_W-1:0]    region_end;
	logic [SIZE_W-1:0]   size_code;
	logic [COUNT_W-1:0]  entry_count;

	logic [UNIT_W-1:0]   free_head_q;
	logic                free_nonempty_q;
	logic [SPAN_W-1:0]   bump_offset_q;
	logic [COUNT_W-1:0]  used_count_q;
	logic                out_valid_q;
	logic [ADDR_W-1:0]   granted_q;
	status_t             status_q;

	logic                accept;
	logic                rd_en;
	logic                wr_en;
	logic [LINK_W-1:0]   wr_link;
	logic [LINK_W-1:0]   rd_link;
	logic [FUNIT_W-1:0]  free_unit;
	logic [UNIT_W-1:0]   free_idx;
	logic                free_ok;
	logic [CMP_W-1:0]    bump_unit;
	logic                bump_ok;
	logic [ADDR_W-1:0]   bump_addr;
	logic [ADDR_W-1:0]   head_addr;
	logic [CMP_W-1:0]    buf_units;

	fsea_region_cfg #(
		.BUFFER_BYTES_LOG2(BUFFER_BYTES_LOG2),
		.CHUNK_BYTES(CHUNK_BYTES),
		.UNIT_BYTES(UNIT_BYTES)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.ctl(cfg_ctl),
		.start_unit(start_unit),
		.region_end(region_end),
		.size_code(size_code),
		.entry_count(entry_count)
	);

	fsea_link_ram #(
		.ADDR_BITS(UNIT_W),
		.DATA_BITS(LINK_W)
	) u_link (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(free_idx),
		.wr_data(wr_link),
		.rd_en(rd_en),
		.rd_addr(free_head_q),
		.rd_data(rd_link)
	);

	assign req.ready = (state_q == ST_IDLE) && !cfg_ctl.busy && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	assign buf_units = CMP_W'(1) << UNIT_W;
	assign free_unit = req.entry_address[ADDR_W-1:UNIT_LOG2];
	assign free_idx  = UNIT_W'(free_unit);
	assign free_ok   = (CMP_W'(free_unit) >= CMP_W'(start_unit))
		&& (CMP_W'(free_unit) < CMP_W'(region_end))
		&& (CMP_W'(free_unit) < buf_units);
	assign wr_link   = free_nonempty_q ? (LINK_W'(free_head_q) + LINK_W'(1)) : '0;
	assign wr_en     = accept && (req.kind == KIND_FREE) && free_ok;
	assign rd_en     = accept && (req.kind == KIND_ALLOC) && free_nonempty_q;

	assign bump_unit = CMP_W'(start_unit) + CMP_W'(bump_offset_q);
	assign bump_ok   = (used_count_q < entry_count) && (bump_unit < CMP_W'(region_end));
	assign bump_addr = ADDR_W'({bump_unit[UNIT_W-1:0], {UNIT_LOG2{1'b0}}});
	assign head_addr = ADDR_W'({free_head_q, {UNIT_LOG2{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			free_head_q     <= '0;
			free_nonempty_q <= 1'b0;
			bump_offset_q   <= '0;
			used_count_q    <= '0;
			out_valid_q     <= 1'b0;
			granted_q       <= '0;
			status_q        <= ST_OK;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_ctl.clear) begin
				free_head_q     <= '0;
				free_nonempty_q <= 1'b0;
				bump_offset_q   <= '0;
				used_count_q    <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.kind == KIND_FREE) begin
							out_valid_q <= 1'b1;
							granted_q   <= '0;
							if (free_ok) begin
								free_head_q     <= free_idx;
								free_nonempty_q <= 1'b1;
								status_q        <= ST_OK;
							end else begin
								status_q <= ST_OUTSIDE;
							end
						end else if (free_nonempty_q) begin
							state_q <= ST_POP;
						end else begin
							out_valid_q <= 1'b1;
							if (bump_ok) begin
								granted_q     <= bump_addr;
								status_q      <= ST_OK;
								bump_offset_q <= bump_offset_q + SPAN_W'(size_code) + SPAN_W'(1);
								used_count_q  <= used_count_q + COUNT_W'(1);
							end else begin
								granted_q <= '0;
								status_q  <= ST_EXHAUSTED;
							end
						end
					end
				end
				ST_POP: begin
					out_valid_q <= 1'b1;
					granted_q   <= head_addr;
					status_q    <= ST_OK;
					state_q     <= ST_IDLE;
					if (rd_link == '0) begin
						free_nonempty_q <= 1'b0;
						free_head_q     <= '0;
					end else begin
						free_head_q <= UNIT_W'(rd_link - LINK_W'(1));
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.granted_address = granted_q;
	assign rsp.status          = status_q;

	`FSEA_ASSERT_IMPL(a_pop_slot_free, clk, arst_n, state_q == ST_POP, !out_valid_q)
	`FSEA_ASSERT_NEXT(a_pop_follows_read, clk, arst_n, rd_en, state_q == ST_POP)
	`FSEA_ASSERT_IMPL(a_busy_holds_req, clk, arst_n, cfg_ctl.busy, !req.ready)
	`FSEA_ASSERT_IMPL(a_empty_head_zero, clk, arst_n, !free_nonempty_q, free_head_q == '0)

endmodule
`default_nettype wire
